// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, disabled while the active-low reset is asserted
`define DV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// clocked assertion that also holds during reset
`define DV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ===== rtl/core/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// Types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;
    localparam int NODES   = 16;
    localparam int IDX_W   = 4;
    localparam int COST_W  = 16;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam logic [COST_W-1:0] COST_INF = '1;

    localparam logic [1:0] REQ_LINK  = 2'd0;
    localparam logic [1:0] REQ_VEC   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] RES_ENTRY  = 2'd0;
    localparam logic [1:0] RES_ROUTE  = 2'd1;
    localparam logic [1:0] RES_NONBR  = 2'd2;
    localparam logic [1:0] RES_NOUPD  = 2'd3;

    localparam logic [1:0] REG_OWN_NODE = 2'd0;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  peer_node;
        logic [IDX_W-1:0]  target_node;
        logic [COST_W-1:0] path_cost;
        logic              final_entry;
    } t_item;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [IDX_W-1:0]  dest_index;
        logic [COST_W-1:0] dest_cost;
        logic [IDX_W-1:0]  next_hop_node;
        logic              hop_known;
        logic              dest_known;
        logic              cost_lowered;
        logic              run_last;
    } t_res;
endpackage

// ===== rtl/core/dvrt_front.sv =====
// ----------------------------------------------------------------------------
// dvrt_front
// Input acceptance and two-entry item queue toward the back end.
// ----------------------------------------------------------------------------
module dvrt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dvrt_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_q_valid,
    output dvrt_pkg::t_item o_q_item
);
    import dvrt_pkg::*;

    t_item      r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_buf[r_wp] <= i_item;
    end
endmodule

// ===== rtl/core/dvrt_back.sv =====
// ----------------------------------------------------------------------------
// dvrt_back
// Table state, vector store and relaxation sequencer with output register.
// ----------------------------------------------------------------------------
module dvrt_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [dvrt_pkg::IDX_W-1:0] i_own_node,
    input  logic                     i_q_valid,
    input  dvrt_pkg::t_item          i_q_item,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output dvrt_pkg::t_res           o_res
);
    import dvrt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_VWR  = 3'd1;
    localparam logic [2:0] S_RRD  = 3'd2;
    localparam logic [2:0] S_REX  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        r_state;
    t_item             r_it;
    logic [COST_W-1:0] r_dcost [NODES];
    logic [IDX_W-1:0]  r_nhop  [NODES];
    logic [COST_W-1:0] r_lcost [NODES];
    logic [NODES-1:0]  r_dknown, r_nhk, r_nbr;
    logic [NODES*NODES-1:0] r_present;
    logic              r_changed;
    logic [COST_W-1:0] r_mem [NODES*NODES];
    logic [COST_W-1:0] r_rdata;
    logic [IDX_W-1:0]  r_d, r_v;
    logic [COST_W-1:0] r_cur;
    logic              r_low, r_relax;
    t_res              r_pend;
    logic              r_ov;
    t_res              r_out;

    logic              w_re, w_we;
    logic [ADDR_W-1:0] w_ra, w_wa;
    logic [COST_W:0]   w_sum;
    logic [COST_W-1:0] w_cand;
    logic              w_ok, w_better, w_last, w_free;
    logic [COST_W-1:0] w_cur_new;
    logic              w_low_new;
    logic [ADDR_W-1:0] w_pv;

    assign o_valid = r_ov;
    assign o_res   = r_out;
    assign w_free  = !r_ov || i_ready;
    assign o_pop   = (r_state == S_IDLE) && i_q_valid;

    assign w_pv   = {r_v, r_d};
    assign w_sum  = {1'b0, r_lcost[r_v]} + {1'b0, r_rdata};
    assign w_cand = w_sum[COST_W] ? COST_INF : w_sum[COST_W-1:0];
    assign w_ok   = r_nbr[r_v] && r_present[w_pv] && (r_rdata != '0);
    assign w_better  = w_ok && (w_cand < r_cur);
    assign w_cur_new = w_better ? w_cand : r_cur;
    assign w_low_new = r_low || w_better;
    assign w_last = ((r_dknown >> ({1'b0, r_d} + 5'd1)) == '0);

    always_comb begin
        w_re = 1'b0;
        w_ra = {i_q_item.peer_node, i_q_item.target_node};
        w_we = 1'b0;
        w_wa = {r_it.peer_node, r_it.target_node};
        if (o_pop && i_q_item.req_type == REQ_VEC) w_re = 1'b1;
        if (r_state == S_RRD) begin
            w_re = 1'b1;
            w_ra = w_pv;
        end
        if (r_state == S_VWR) w_we = !r_present[w_wa] || (r_rdata != r_it.path_cost);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= r_it.path_cost;
        if (w_re) r_rdata <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dknown  <= '0;
            r_nhk     <= '0;
            r_nbr     <= '0;
            r_present <= '0;
            r_changed <= 1'b0;
            r_ov      <= 1'b0;
            r_relax   <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                r_dcost[i] <= COST_INF;
                r_nhop[i]  <= '0;
                r_lcost[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_it <= i_q_item;
                        r_relax <= 1'b0;
                        unique case (i_q_item.req_type)
                            REQ_LINK: begin
                                if (i_q_item.peer_node != i_own_node &&
                                    !r_nbr[i_q_item.peer_node]) begin
                                    r_nbr[i_q_item.peer_node]   <= 1'b1;
                                    r_lcost[i_q_item.peer_node] <= i_q_item.path_cost;
                                    if (!r_dknown[i_q_item.peer_node] ||
                                        i_q_item.path_cost < r_dcost[i_q_item.peer_node]) begin
                                        r_dknown[i_q_item.peer_node] <= 1'b1;
                                        r_dcost[i_q_item.peer_node]  <= i_q_item.path_cost;
                                        r_nhop[i_q_item.peer_node]   <= i_q_item.peer_node;
                                        r_nhk[i_q_item.peer_node]    <= 1'b1;
                                    end
                                end
                            end
                            REQ_VEC: begin
                                if (!r_nbr[i_q_item.peer_node]) begin
                                    r_pend <= '{RES_NONBR, i_q_item.target_node, '0,
                                                '0, 1'b0, 1'b0, 1'b0, 1'b1};
                                    r_state <= S_OUT;
                                end else begin
                                    if (i_q_item.target_node != i_own_node &&
                                        !r_dknown[i_q_item.target_node]) begin
                                        r_dknown[i_q_item.target_node] <= 1'b1;
                                        r_dcost[i_q_item.target_node]  <= COST_INF;
                                    end
                                    r_state <= S_VWR;
                                end
                            end
                            REQ_QUERY: begin
                                if (!r_dknown[i_q_item.target_node])
                                    r_pend <= '{RES_ROUTE, i_q_item.target_node, COST_INF,
                                                '0, 1'b0, 1'b0, 1'b0, 1'b1};
                                else
                                    r_pend <= '{RES_ROUTE, i_q_item.target_node,
                                                r_dcost[i_q_item.target_node],
                                                r_nhop[i_q_item.target_node],
                                                r_nhk[i_q_item.target_node],
                                                1'b1, 1'b0, 1'b1};
                                r_state <= S_OUT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_VWR: begin
                    r_present[w_wa] <= 1'b1;
                    if (!r_it.final_entry) begin
                        if (w_we) r_changed <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_changed <= 1'b0;
                        if ((r_changed || w_we) && r_dknown != '0) begin
                            r_d <= '0;
                            r_v <= '0;
                            r_state <= S_RRD;
                        end else begin
                            r_pend <= '{RES_NOUPD, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1};
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RRD: begin
                    if (!r_dknown[r_d]) begin
                        r_d <= r_d + 1'b1;
                    end else begin
                        if (r_v == '0) begin
                            r_cur <= r_dcost[r_d];
                            r_low <= 1'b0;
                        end
                        r_state <= S_REX;
                    end
                end
                S_REX: begin
                    r_cur <= w_cur_new;
                    r_low <= w_low_new;
                    if (w_better) begin
                        r_nhop[r_d] <= r_v;
                        r_nhk[r_d]  <= 1'b1;
                    end
                    if (r_v == IDX_W'(NODES - 1)) begin
                        r_dcost[r_d] <= w_cur_new;
                        r_pend <= '{RES_ENTRY, r_d, w_cur_new,
                                    w_better ? r_v : r_nhop[r_d],
                                    w_better | r_nhk[r_d], 1'b1, w_low_new, w_last};
                        r_relax <= !w_last;
                        r_v <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_v <= r_v + 1'b1;
                        r_state <= S_RRD;
                    end
                end
                S_OUT: begin
                    if (w_free) begin
                        r_out <= r_pend;
                        if (r_relax) begin
                            r_d <= r_d + 1'b1;
                            r_state <= S_RRD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_OUT && w_free) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/core/distance_vector_route_table_top.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_table_top
// Distance-vector route table: link installs, neighbour vectors with
// Bellman-Ford relaxation, and route queries.
// ----------------------------------------------------------------------------
// Queries and rejections are held until the output register is free. A final
// vector entry that triggers relaxation walks every known destination, with one
// vector-store read and one compare per candidate next-hop node (single store
// read port), and skips unknown destinations. A two-entry queue lets the input
// side run ahead of the table engine.
module distance_vector_route_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_peer_node,
    input  logic [3:0]  i_target_node,
    input  logic [15:0] i_path_cost,
    input  logic        i_final_entry,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [3:0]  o_dest_index,
    output logic [15:0] o_dest_cost,
    output logic [3:0]  o_next_hop_node,
    output logic        o_hop_known,
    output logic        o_dest_known,
    output logic        o_cost_lowered,
    output logic        o_run_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dvrt_pkg::*;

    logic [IDX_W-1:0] r_own_node;
    t_item            w_item, w_q_item;
    t_res             w_res;
    logic             w_q_valid;
    logic             w_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_OWN_NODE) ? {{(32-IDX_W){1'b0}}, r_own_node} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_node <= '0;
        end else if (psel && penable && pwrite && paddr == REG_OWN_NODE) begin
            r_own_node <= pwdata[IDX_W-1:0];
        end
    end

    assign w_item = '{i_req_type, i_peer_node, i_target_node, i_path_cost, i_final_entry};

    dvrt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (w_item),
        .i_pop     (w_pop),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item)
    );

    dvrt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_own_node (r_own_node),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (w_res)
    );

    assign o_result_kind   = w_res.result_kind;
    assign o_dest_index    = w_res.dest_index;
    assign o_dest_cost     = w_res.dest_cost;
    assign o_next_hop_node = w_res.next_hop_node;
    assign o_hop_known     = w_res.hop_known;
    assign o_dest_known    = w_res.dest_known;
    assign o_cost_lowered  = w_res.cost_lowered;
    assign o_run_last      = w_res.run_last;
endmodule

// ===== rtl/core/dvrt_checker.sv =====
// ----------------------------------------------------------------------------
// dvrt_checker
// Port-level checks of the route table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dvrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_result_kind,
    input logic [15:0] o_dest_cost,
    input logic        o_dest_known,
    input logic        o_cost_lowered,
    input logic        o_run_last
);
    import dvrt_pkg::*;

    `DV_ASSERT(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_result_kind))
    `DV_ASSERT(a_single, i_clk, i_rst_n, o_valid && o_result_kind != RES_ENTRY |-> o_run_last)
    `DV_ASSERT(a_lowered, i_clk, i_rst_n, o_valid && o_cost_lowered |-> o_result_kind == RES_ENTRY && o_dest_known)
    `DV_ASSERT(a_unknown, i_clk, i_rst_n, o_valid && o_result_kind == RES_ROUTE && !o_dest_known |-> o_dest_cost == COST_INF)
endmodule

bind distance_vector_route_table_top dvrt_checker u_dvrt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_result_kind  (o_result_kind),
    .o_dest_cost    (o_dest_cost),
    .o_dest_known   (o_dest_known),
    .o_cost_lowered (o_cost_lowered),
    .o_run_last     (o_run_last)
);

// ===== dv/tb_distance_vector_route_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_distance_vector_route_table_top
// Self-checking bench for the distance-vector route table. A queue of pending
// items feeds a valid/ready driver. Each accepted item runs through a local
// route-table predictor, which queues the expected results. A monitor checks
// every accepted result field by field. own_node is rewritten over APB
// between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_table_top;
    import dvrt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF   = 600;
    localparam int STALL_MAX  = 4000;
    localparam int PHASE_RAND = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [3:0]  i_peer_node = '0;
    logic [3:0]  i_target_node = '0;
    logic [15:0] i_path_cost = '0;
    logic        i_final_entry = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_result_kind;
    logic [3:0]  o_dest_index;
    logic [15:0] o_dest_cost;
    logic [3:0]  o_next_hop_node;
    logic        o_hop_known;
    logic        o_dest_known;
    logic        o_cost_lowered;
    logic        o_run_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    distance_vector_route_table_top dut (.*);

    always #10 i_clk = ~i_clk;

    // route-table predictor state
    logic [IDX_W-1:0]  rt_own;
    logic [COST_W-1:0] rt_cost [NODES];
    logic              rt_known [NODES];
    logic [IDX_W-1:0]  rt_hop [NODES];
    logic              rt_hop_ok [NODES];
    logic [COST_W-1:0] rt_link [NODES];
    logic              rt_nbr [NODES];
    logic [COST_W-1:0] adv_cost [NODES*NODES];
    logic              adv_ok [NODES*NODES];
    logic              adv_dirty;

    t_item pend_q [$];
    t_res  route_exp_q [$];
    t_item cur_item;
    int    in_gap = 0;
    int    out_gap = 0;
    bit    quiet = 0;
    int    errors = 0;
    int    stall_cnt = 0;

    function automatic t_res mk_res(logic [1:0] k, logic [3:0] d, logic [15:0] c,
                                    logic [3:0] h, logic hk, logic dk, logic lo,
                                    logic last);
        t_res r;
        r.result_kind = k; r.dest_index = d; r.dest_cost = c; r.next_hop_node = h;
        r.hop_known = hk; r.dest_known = dk; r.cost_lowered = lo; r.run_last = last;
        return r;
    endfunction

    function automatic void route_update(t_item it);
        int idx;
        int n;
        logic [COST_W-1:0] cur;
        logic [COST_W:0] sum;
        logic lowered;
        t_res r;
        n = 0;
        case (it.req_type)
            REQ_LINK: begin
                if (it.peer_node != rt_own && !rt_nbr[it.peer_node]) begin
                    rt_nbr[it.peer_node] = 1;
                    rt_link[it.peer_node] = it.path_cost;
                    if (!rt_known[it.peer_node] || it.path_cost < rt_cost[it.peer_node]) begin
                        rt_known[it.peer_node] = 1;
                        rt_cost[it.peer_node] = it.path_cost;
                        rt_hop[it.peer_node] = it.peer_node;
                        rt_hop_ok[it.peer_node] = 1;
                    end
                end
            end
            REQ_VEC: begin
                if (!rt_nbr[it.peer_node]) begin
                    route_exp_q.push_back(mk_res(RES_NONBR, it.target_node, 0, 0, 0, 0, 0, 1));
                end else begin
                    if (it.target_node != rt_own && !rt_known[it.target_node]) begin
                        rt_known[it.target_node] = 1;
                        rt_cost[it.target_node] = COST_INF;
                    end
                    idx = it.peer_node * NODES + it.target_node;
                    if (!adv_ok[idx] || adv_cost[idx] != it.path_cost) begin
                        adv_cost[idx] = it.path_cost;
                        adv_ok[idx] = 1;
                        adv_dirty = 1;
                    end
                    if (it.final_entry) begin
                        if (adv_dirty) begin
                            for (int d = 0; d < NODES; d++) begin
                                if (!rt_known[d]) continue;
                                cur = rt_cost[d];
                                lowered = 0;
                                for (int v = 0; v < NODES; v++) begin
                                    if (!rt_nbr[v] || !adv_ok[v*NODES+d]) continue;
                                    if (adv_cost[v*NODES+d] == 0) continue;
                                    sum = {1'b0, rt_link[v]} + {1'b0, adv_cost[v*NODES+d]};
                                    if (sum > {1'b0, COST_INF}) sum = {1'b0, COST_INF};
                                    if (sum[COST_W-1:0] < cur) begin
                                        cur = sum[COST_W-1:0];
                                        rt_hop[d] = IDX_W'(v);
                                        rt_hop_ok[d] = 1;
                                        lowered = 1;
                                    end
                                end
                                rt_cost[d] = cur;
                                if (n < 16) begin
                                    route_exp_q.push_back(mk_res(RES_ENTRY, d, cur, rt_hop[d],
                                                                 rt_hop_ok[d], 1, lowered, 0));
                                    n++;
                                end
                            end
                        end
                        adv_dirty = 0;
                        if (n == 0) begin
                            route_exp_q.push_back(mk_res(RES_NOUPD, 0, 0, 0, 0, 0, 0, 1));
                        end else begin
                            r = route_exp_q.pop_back();
                            r.run_last = 1;
                            route_exp_q.push_back(r);
                        end
                    end
                end
            end
            REQ_QUERY: begin
                if (!rt_known[it.target_node])
                    route_exp_q.push_back(mk_res(RES_ROUTE, it.target_node, COST_INF,
                                                 0, 0, 0, 0, 1));
                else
                    route_exp_q.push_back(mk_res(RES_ROUTE, it.target_node,
                                                 rt_cost[it.target_node],
                                                 rt_hop[it.target_node],
                                                 rt_hop_ok[it.target_node], 1, 0, 1));
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nv = i_valid;
            if (i_valid && o_ready) begin
                route_update(cur_item);
                nv = 1'b0;
            end
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pend_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 5) == 0) begin
                        in_gap = $urandom_range(1, 18);
                    end else begin
                        cur_item = pend_q.pop_front();
                        nv = 1'b1;
                        i_req_type <= cur_item.req_type;
                        i_peer_node <= cur_item.peer_node;
                        i_target_node <= cur_item.target_node;
                        i_path_cost <= cur_item.path_cost;
                        i_final_entry <= cur_item.final_entry;
                    end
                end
            end
            i_valid <= nv;
        end
    end

    function automatic void chk(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (route_exp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d dest %0d",
                             $time, o_result_kind, o_dest_index);
                    errors++;
                end else begin
                    e = route_exp_q.pop_front();
                    chk("result_kind", e.result_kind, o_result_kind);
                    chk("dest_index", e.dest_index, o_dest_index);
                    chk("dest_cost", e.dest_cost, o_dest_cost);
                    chk("next_hop_node", e.next_hop_node, o_next_hop_node);
                    chk("hop_known", e.hop_known, o_hop_known);
                    chk("dest_known", e.dest_known, o_dest_known);
                    chk("cost_lowered", e.cost_lowered, o_cost_lowered);
                    chk("run_last", e.run_last, o_run_last);
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(0, 17);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cnt <= 0;
        end else if (pend_q.size() > 0 || i_valid || route_exp_q.size() > 0) begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("tb_distance_vector_route_table_top NOT OK");
                $finish;
            end
        end
    end

    function automatic t_item mk_item(logic [1:0] k, logic [3:0] p, logic [3:0] t,
                                      logic [15:0] c, logic f);
        t_item it;
        it.req_type = k; it.peer_node = p; it.target_node = t;
        it.path_cost = c; it.final_entry = f;
        return it;
    endfunction

    function automatic logic [15:0] pick_cost();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'hFFFE;
            3, 4: return 16'($urandom);
            default: return 16'($urandom_range(1, 200));
        endcase
    endfunction

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        rt_own = data[IDX_W-1:0];
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || i_valid || route_exp_q.size() > 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic add_random(int count);
        int made;
        int len;
        int r;
        logic [3:0] p;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            p = 4'($urandom);
            if (r < 12) begin
                pend_q.push_back(mk_item(REQ_LINK, p, 4'($urandom), pick_cost(), 1'($urandom)));
                made++;
            end else if (r < 60) begin
                for (int k = 0; k < 16 && !rt_nbr[p]; k++) p = 4'($urandom);
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    pend_q.push_back(mk_item(REQ_VEC, p, 4'($urandom), pick_cost(),
                                             k == len - 1));
                made += len;
            end else if (r < 80) begin
                pend_q.push_back(mk_item(REQ_QUERY, p, 4'($urandom), pick_cost(),
                                         1'($urandom)));
                made++;
            end else if (r < 93) begin
                pend_q.push_back(mk_item(REQ_VEC, p, 4'($urandom), pick_cost(), 1'($urandom)));
                made++;
            end else begin
                pend_q.push_back(mk_item(2'd3, p, 4'($urandom), 16'($urandom), 1'($urandom)));
                made++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NODES; i++) begin
            rt_cost[i] = COST_INF; rt_known[i] = 0; rt_hop[i] = 0; rt_hop_ok[i] = 0;
            rt_link[i] = 0; rt_nbr[i] = 0;
        end
        for (int i = 0; i < NODES*NODES; i++) begin
            adv_cost[i] = 0; adv_ok[i] = 0;
        end
        adv_dirty = 0;
        rt_own = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_write(REG_OWN_NODE, 32'd0);

        pend_q.push_back(mk_item(REQ_QUERY, 0, 5, 0, 0));
        pend_q.push_back(mk_item(REQ_VEC, 3, 4, 9, 1));
        pend_q.push_back(mk_item(REQ_LINK, 0, 0, 4, 0));
        pend_q.push_back(mk_item(REQ_LINK, 1, 0, 0, 0));
        pend_q.push_back(mk_item(REQ_LINK, 2, 15, 10, 1));
        pend_q.push_back(mk_item(REQ_LINK, 15, 0, 16'hFFFF, 0));
        pend_q.push_back(mk_item(REQ_LINK, 1, 0, 5, 0));
        pend_q.push_back(mk_item(REQ_VEC, 2, 0, 3, 0));
        pend_q.push_back(mk_item(REQ_VEC, 2, 5, 0, 0));
        pend_q.push_back(mk_item(REQ_VEC, 2, 9, 7, 1));
        pend_q.push_back(mk_item(REQ_VEC, 2, 9, 7, 1));
        pend_q.push_back(mk_item(REQ_VEC, 15, 5, 16'hFFFF, 1));
        pend_q.push_back(mk_item(REQ_VEC, 1, 5, 20, 1));
        pend_q.push_back(mk_item(REQ_VEC, 1, 5, 2, 1));
        pend_q.push_back(mk_item(REQ_VEC, 1, 15, 16'hFFFE, 1));
        pend_q.push_back(mk_item(REQ_QUERY, 15, 5, 16'hFFFF, 1));
        pend_q.push_back(mk_item(REQ_QUERY, 0, 9, 0, 0));
        pend_q.push_back(mk_item(REQ_QUERY, 0, 0, 0, 0));
        pend_q.push_back(mk_item(2'd3, 15, 15, 16'hFFFF, 1));
        add_random(PHASE_RAND);
        drain();

        apb_write(REG_OWN_NODE, 32'd15);
        add_random(PHASE_RAND);
        drain();

        apb_write(REG_OWN_NODE, 32'($urandom_range(1, 14)));
        add_random(PHASE_RAND);
        drain();

        apb_write(REG_OWN_NODE, 32'd7);
        quiet = 1;
        add_random(PHASE_RAND);
        drain();

        if (errors == 0)
            $display("tb_distance_vector_route_table_top OK");
        else
            $display("tb_distance_vector_route_table_top NOT OK");
        $finish;
    end
endmodule
